[hdl/adll_pkg.sv]
// ----------------------------------------------------------------------------
// adll_pkg
// Shared types and constants for the array-based doubly linked list block.
// ----------------------------------------------------------------------------
package adll_pkg;

  localparam int KEY_W       = 31;
  localparam int NAME_HEAD_W = 64;
  localparam int NAME_TAIL_W = 16;
  localparam int FEE_W       = 24;
  localparam int REC_W       = KEY_W + NAME_HEAD_W + NAME_TAIL_W + FEE_W;
  localparam int DATA_W      = ((REC_W + 7) / 8) * 8;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_TRAVERSE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Key sits in the lowest bits, fee in the highest.
  typedef struct packed {
    logic [FEE_W-1:0]       fee;
    logic [NAME_TAIL_W-1:0] name_tail;
    logic [NAME_HEAD_W-1:0] name_head;
    logic [KEY_W-1:0]       key;
  } rec_t;

  typedef struct packed {
    op_t  op;
    rec_t rec;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_EMIT
  } back_state_t;

endpackage

[hdl/adll_front.sv]
// ----------------------------------------------------------------------------
// adll_front
// Input stage: registers each accepted item, decodes the operation and drops
// items with the unused operation code.
// ----------------------------------------------------------------------------
module adll_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [adll_pkg::DATA_W-1:0]  s_axis_tdata,  // record_key, name_head, name_tail, fee_cents
  input  logic [adll_pkg::OP_W-1:0]    s_axis_tuser,  // operation
  output logic                         cmd_valid,
  output adll_pkg::cmd_t               cmd,
  input  logic                         cmd_ready
);
  import adll_pkg::*;

  logic hold_valid;
  logic keep;

  assign keep = (s_axis_tuser == OP_INSERT) || (s_axis_tuser == OP_REMOVE) ||
                (s_axis_tuser == OP_TRAVERSE);

  assign s_axis_tready = !hold_valid || cmd_ready;
  assign cmd_valid     = hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_axis_tready) begin
      // drop items that carry no operation
      hold_valid <= s_axis_tvalid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cmd.op  <= op_t'(s_axis_tuser);
      cmd.rec <= rec_t'(s_axis_tdata[REC_W-1:0]);
    end
  end

endmodule

[hdl/adll_fifo.sv]
// ----------------------------------------------------------------------------
// adll_fifo
// Short command queue between the input stage and the list engine.
// ----------------------------------------------------------------------------
module adll_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  adll_pkg::cmd_t in_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output adll_pkg::cmd_t out_cmd
);
  import adll_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic          push;
  logic          pop;

  assign in_ready  = (fill != FW'(QUEUE_DEPTH));
  assign out_valid = (fill != '0);
  assign out_cmd   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + FW'(1);
      end else if (pop && !push) begin
        fill <= fill - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

endmodule

[hdl/adll_back.sv]
// ----------------------------------------------------------------------------
// adll_back
// List engine: owns the record store and the entry count, carries out
// insert, remove and traverse, and drives the registered result port.
// ----------------------------------------------------------------------------
module adll_back #(
  parameter int SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  adll_pkg::cmd_t                cmd,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [adll_pkg::DATA_W-1:0]   m_axis_tdata,  // out_key, out_name_head, out_name_tail, out_fee_cents
  output logic [adll_pkg::STATUS_W-1:0] m_axis_tuser,  // status
  output logic                          m_axis_tlast   // last
);
  import adll_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  // Slots are taken lowest-free and freed only at the head, so the used
  // slots are always 0..count-1 with the head at count-1 and each next link
  // pointing one slot down. The links therefore follow from the count.
  rec_t store [SLOTS];
  rec_t rd_rec;

  back_state_t   state, state_next;
  logic [CW-1:0] count, count_next;
  logic [SW-1:0] cur, cur_next;

  logic    ovalid;
  status_t ostatus;
  rec_t    orec;
  logic    olast;

  logic    out_free;
  logic    load;
  status_t ld_status;
  rec_t    ld_rec;
  logic    ld_last;
  logic    wr_en;

  assign out_free = !ovalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      count <= '0;
      cur   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      cur   <= cur_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    cur_next   = cur;
    cmd_ready  = 1'b0;
    load       = 1'b0;
    ld_status  = ST_DONE;
    ld_rec     = '0;
    ld_last    = 1'b1;
    wr_en      = 1'b0;
    case (state)
      BK_IDLE: begin
        cmd_ready = out_free;
        if (cmd_valid && out_free) begin
          case (cmd.op)
            OP_INSERT: begin
              load = 1'b1;
              if (count == CW'(SLOTS)) begin
                ld_status = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + CW'(1);
              end
            end
            OP_REMOVE: begin
              load = 1'b1;
              if (count == '0) begin
                ld_status = ST_EMPTY;
              end else begin
                count_next = count - CW'(1);
              end
            end
            OP_TRAVERSE: begin
              if (count == '0) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                cur_next   = SW'(count - CW'(1));
                state_next = BK_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      BK_FETCH: begin
        // store read is registered: wait here for the record
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          load    = 1'b1;
          ld_rec  = rd_rec;
          ld_last = (cur == '0);
          if (cur == '0) begin
            state_next = BK_IDLE;
          end else begin
            cur_next   = cur - SW'(1);
            state_next = BK_FETCH;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[count[SW-1:0]] <= cmd.rec;
    end
    rd_rec <= store[cur];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (load) begin
      ovalid <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ostatus <= ld_status;
      orec    <= ld_rec;
      olast   <= ld_last;
    end
  end

  assign m_axis_tvalid = ovalid;
  assign m_axis_tuser  = ostatus;
  assign m_axis_tdata  = {{(DATA_W - REC_W){1'b0}}, orec};
  assign m_axis_tlast  = olast;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(SLOTS))
    else $error("entry count above slot count");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    state != BK_IDLE |-> count != '0)
    else $error("traverse running on an empty list");

  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    (state == BK_EMIT && out_free && cur == '0) |=>
      (state == BK_IDLE && m_axis_tvalid && m_axis_tlast))
    else $error("final record of a traverse not marked last");

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && ostatus != ST_DONE) |-> (orec == '0 && olast))
    else $error("status result carries record data or is not last");
`endif

endmodule

[hdl/array_doubly_linked_list.sv]
// ----------------------------------------------------------------------------
// array_doubly_linked_list
// Doubly linked list of records in a fixed slot store with insert-head,
// remove-head and head-to-tail traverse.
// ----------------------------------------------------------------------------
// An item passes an input register and a two-entry command queue before the
// list engine takes it. Insert and remove give one result each. Traverse gives
// one result per stored record, each record passing the registered read of the
// record store in the fetch state before it is emitted; an empty list gives one
// status result. A stalled receiver holds the engine back. The store needs no
// clearing after reset. Operation code three is dropped at the input and gives
// no result.
module array_doubly_linked_list #(
  parameter int SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [adll_pkg::DATA_W-1:0]   s_axis_tdata,  // record_key, name_head, name_tail, fee_cents
  input  logic [adll_pkg::OP_W-1:0]     s_axis_tuser,  // operation
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [adll_pkg::DATA_W-1:0]   m_axis_tdata,  // out_key, out_name_head, out_name_tail, out_fee_cents
  output logic [adll_pkg::STATUS_W-1:0] m_axis_tuser,  // status
  output logic                          m_axis_tlast   // last
);
  import adll_pkg::*;

  logic front_valid;
  logic front_ready;
  cmd_t front_cmd;
  logic back_valid;
  logic back_ready;
  cmd_t back_cmd;

  adll_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid     (front_valid),
    .cmd           (front_cmd),
    .cmd_ready     (front_ready)
  );

  adll_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_cmd    (front_cmd),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_cmd   (back_cmd)
  );

  adll_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (back_valid),
    .cmd_ready     (back_ready),
    .cmd           (back_cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[dv/tb_array_doubly_linked_list.sv]
// ----------------------------------------------------------------------------
// tb_array_doubly_linked_list
// Self-checking bench for the slot-store doubly linked list. A mirror of the
// list predicts every result item of insert-head, remove-head and traverse.
// Directed corner cases, a long receiver hold-off, an idle-free burst and
// random fill/drain traffic drive the block. Results are compared in order.
// ----------------------------------------------------------------------------
module tb_array_doubly_linked_list;
  import adll_pkg::*;

  localparam int SLOTS = 16;
  localparam int NIL = SLOTS;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    status_t status;
    rec_t    rec;
    logic    last;
  } result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DATA_W-1:0]   s_axis_tdata = '0;
  logic [OP_W-1:0]     s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [DATA_W-1:0]   m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;
  logic                m_axis_tlast;

  // Mirror of the list
  rec_t rec_mem   [SLOTS];
  int   prev_slot [SLOTS];
  int   next_slot [SLOTS];
  bit   slot_busy [SLOTS];
  int   head_slot = NIL;
  int   tail_slot = NIL;
  int   list_len = 0;

  result_t expected_results[$];
  int      fail_count = 0;
  int      stall_cycles = 0;
  bit      no_idle = 1'b0;
  int      hold_left = 0;

  array_doubly_linked_list #(
    .SLOTS(SLOTS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #4 clk = ~clk;

  // Receiver: long hold-off on request, always ready in no-idle mode, otherwise random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 17);
    end
  end

  function automatic void expect_status(status_t st);
    result_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_list_op(logic [OP_W-1:0] op_bits, rec_t rec);
    int slot;
    int cur;
    result_t r;
    slot = NIL;
    if (op_bits == OP_INSERT) begin
      for (int i = SLOTS - 1; i >= 0; i--) if (!slot_busy[i]) slot = i;
      if (list_len >= SLOTS || slot == NIL) begin
        expect_status(ST_FULL);
      end else begin
        rec_mem[slot] = rec;
        slot_busy[slot] = 1'b1;
        prev_slot[slot] = NIL;
        if (list_len == 0 || head_slot == NIL) begin
          next_slot[slot] = NIL;
          tail_slot = slot;
        end else begin
          next_slot[slot] = head_slot;
          prev_slot[head_slot] = slot;
        end
        head_slot = slot;
        list_len++;
        expect_status(ST_DONE);
      end
    end else if (op_bits == OP_REMOVE) begin
      if (list_len == 0 || head_slot == NIL) begin
        expect_status(ST_EMPTY);
      end else begin
        cur = head_slot;
        if (list_len == 1) begin
          head_slot = NIL;
          tail_slot = NIL;
        end else begin
          head_slot = next_slot[cur];
          if (head_slot != NIL) prev_slot[head_slot] = NIL;
        end
        prev_slot[cur] = NIL;
        next_slot[cur] = NIL;
        slot_busy[cur] = 1'b0;
        list_len--;
        expect_status(ST_DONE);
      end
    end else if (op_bits == OP_TRAVERSE) begin
      if (list_len == 0 || head_slot == NIL) begin
        expect_status(ST_EMPTY);
      end else begin
        cur = head_slot;
        for (int k = 0; k < list_len && cur != NIL; k++) begin
          r.status = ST_DONE;
          r.rec = rec_mem[cur];
          r.last = 1'b0;
          expected_results.push_back(r);
          cur = next_slot[cur];
        end
        expected_results[expected_results.size() - 1].last = 1'b1;
      end
    end
    // unused code: no result, no change
  endfunction

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result();
    result_t want;
    rec_t    got;
    got = m_axis_tdata[REC_W-1:0];
    if (expected_results.size() == 0) begin
      $display("%0t: result item expected none actual status %0d data %h last %b",
               $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
      fail_count++;
    end else begin
      want = expected_results.pop_front();
      check_field("status", 64'(want.status), 64'(m_axis_tuser));
      check_field("out_key", 64'(want.rec.key), 64'(got.key));
      check_field("out_name_head", want.rec.name_head, got.name_head);
      check_field("out_name_tail", 64'(want.rec.name_tail), 64'(got.name_tail));
      check_field("out_fee_cents", 64'(want.rec.fee), 64'(got.fee));
      check_field("last", 64'(want.last), 64'(m_axis_tlast));
    end
  endfunction

  // Predict on input acceptance first, then check the output side
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) predict_list_op(s_axis_tuser, s_axis_tdata[REC_W-1:0]);
      if (m_axis_tvalid && m_axis_tready) check_result();
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no item accepted for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Leave tvalid high after acceptance; the next call or wait_drain drives it
  task automatic send_item(logic [OP_W-1:0] op_bits, rec_t rec);
    if (!no_idle) begin
      while ($urandom_range(99) < 17) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op_bits;
    s_axis_tdata <= DATA_W'(rec);
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0);
    @(posedge clk);
  endtask

  task automatic set_no_idle(bit v);
    @(negedge clk);
    no_idle = v;
    @(posedge clk);
  endtask

  function automatic rec_t random_record();
    rec_t r;
    r.key = KEY_W'($urandom);
    r.name_head = {$urandom, $urandom};
    r.name_tail = NAME_TAIL_W'($urandom);
    r.fee = FEE_W'($urandom);
    return r;
  endfunction

  function automatic rec_t corner_record(int idx);
    logic [159:0] pattern;
    case (idx)
      0: pattern = '0;
      1: pattern = '1;
      2: pattern = {5{32'h5555_5555}};
      3: pattern = {5{32'hAAAA_AAAA}};
      default: pattern = {$urandom, $urandom, $urandom, $urandom, $urandom};
    endcase
    return pattern[REC_W-1:0];
  endfunction

  function automatic logic [OP_W-1:0] pick_op(bit filling);
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return OP_UNUSED;
    if (roll < 25) return OP_TRAVERSE;
    if (filling) return (roll < 80) ? OP_INSERT : OP_REMOVE;
    return (roll < 45) ? OP_INSERT : OP_REMOVE;
  endfunction

  // Alternate fill-leaning and drain-leaning stretches to hit full and empty
  task automatic send_random_items(int count);
    int sent;
    logic [OP_W-1:0] op_bits;
    sent = 0;
    while (sent < count) begin
      op_bits = pick_op(((sent / 40) % 2) == 0);
      send_item(op_bits, random_record());
      if (op_bits != OP_UNUSED) sent++;
    end
  endtask

  task automatic test_corner_cases();
    send_item(OP_REMOVE, random_record());
    send_item(OP_TRAVERSE, random_record());
    send_item(OP_UNUSED, random_record());
    for (int i = 0; i < SLOTS; i++) send_item(OP_INSERT, corner_record(i));
    send_item(OP_INSERT, corner_record(1));
    send_item(OP_TRAVERSE, corner_record(0));
    send_item(OP_REMOVE, corner_record(1));
    // freed head slot is the lowest free one again
    send_item(OP_INSERT, corner_record(3));
    send_item(OP_UNUSED, corner_record(1));
    send_item(OP_TRAVERSE, corner_record(2));
    wait_drain();
  endtask

  task automatic test_backpressure();
    @(negedge clk);
    hold_left = HOLD_CYCLES;
    @(posedge clk);
    for (int i = 0; i < 24; i++) begin
      send_item((i % 3 == 0) ? OP_TRAVERSE : pick_op(i < 12), random_record());
    end
    wait_drain();
  endtask

  task automatic test_no_idle_burst();
    set_no_idle(1'b1);
    send_random_items(60);
    wait_drain();
    set_no_idle(1'b0);
  endtask

  task automatic test_random_traffic();
    send_random_items(320);
    wait_drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_cases();
    test_backpressure();
    test_no_idle_burst();
    test_random_traffic();
    // let any late result item reach the checker before the final verdict
    repeat (40) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
